FILE: src/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/mwcs_pkg.sv
// ----------------------------------------------------------------------------
// mwcs_pkg
// Shared types and constants of the max-weight common subsequence engine.
// ----------------------------------------------------------------------------
package mwcs_pkg;

   localparam int DEF_MAX_FIRST_LEN  = 64;
   localparam int DEF_MAX_SECOND_LEN = 64;
   localparam int DEF_MAX_SUBSEQ_LEN = 16;

   localparam int LEN_CFG_W = 5;
   localparam int BEST_W    = 12;
   localparam int STATUS_W  = 2;
   localparam logic [LEN_CFG_W-1:0] LEN_RESET = 5'd1;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_FIRST   = 2'd1,
      ACT_SECOND  = 2'd2,
      ACT_COMPUTE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_FOUND    = 2'd0,
      STAT_NONE     = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Per-cycle control broadcast along the cell chain.
   typedef struct packed {
      logic       en;
      logic       first_col;
      logic       match;
      logic [7:0] ch;
   } cell_ctl_type;

endpackage

FILE: src/mwcs_ram.sv
// ----------------------------------------------------------------------------
// mwcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mwcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/mwcs_cell.sv
// ----------------------------------------------------------------------------
// mwcs_cell
// One length slot of the table: best sum of a common subsequence of its length.
// ----------------------------------------------------------------------------
module mwcs_cell #(
   parameter int SUM_W = 12
) (
   input  logic                  clock,
   input  mwcs_pkg::cell_ctl_type ctl,
   input  logic [SUM_W:0]        prev_here,
   input  logic [SUM_W:0]        diag_in,
   output logic [SUM_W:0]        diag_out,
   output logic [SUM_W:0]        cur_here
);
   import mwcs_pkg::*;

   // Scores carry a valid flag in the top bit; an invalid score loses.
   function automatic logic [SUM_W:0] pick(input logic [SUM_W:0] a, input logic [SUM_W:0] b);
      logic [SUM_W:0] r;
      if (!a[SUM_W]) r = b;
      else if (!b[SUM_W]) r = a;
      else r = (a[SUM_W-1:0] >= b[SUM_W-1:0]) ? a : b;
      return r;
   endfunction

   logic [SUM_W:0] cur_ff;
   logic [SUM_W:0] pleft_ff;
   logic [SUM_W:0] left;
   logic [SUM_W:0] cand;

   always_comb begin
      left = cur_ff;
      if (ctl.first_col) begin
         left[SUM_W] = 1'b0;
      end
      cand = {diag_in[SUM_W], diag_in[SUM_W-1:0] + SUM_W'(ctl.ch)};
      cur_here = pick(prev_here, left);
      if (ctl.match && diag_in[SUM_W]) begin
         cur_here = pick(cur_here, cand);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         cur_ff   <= cur_here;
         pleft_ff <= prev_here;
      end
   end

   assign diag_out = pleft_ff;
endmodule

FILE: src/max_weight_common_subsequence.sv
// ----------------------------------------------------------------------------
// max_weight_common_subsequence
// Largest byte sum of a common subsequence of fixed length of two strings.
// ----------------------------------------------------------------------------
// Usage: words enter on the req_ channel (valid/ready). Action clear, append
// to the first string or append to the second string produces no response
// word. A compute action produces exactly one word on the rsp_ channel
// carrying best_sum and status.
// A compute walks a row of cells over the table, one column a cycle and all
// lengths at once, with a turnaround per row through the row RAM.
// When the length is zero, too large, or a string is empty, the response is
// ready in the next cycle. Loads are taken one per cycle while no compute
// is running.
// The csr_ port writes the subsequence length and should only be used while
// the block is idle.
// Reset clears the string lengths, the overflow flag and any pending word
// and sets the length to 1. No memory is cleared.
// While the receiver stalls, the response word is held; loads are still
// taken, but a further compute waits until the held word is taken.
// ----------------------------------------------------------------------------
module max_weight_common_subsequence #(
   parameter int MAX_FIRST_LEN  = mwcs_pkg::DEF_MAX_FIRST_LEN,
   parameter int MAX_SECOND_LEN = mwcs_pkg::DEF_MAX_SECOND_LEN,
   parameter int MAX_SUBSEQ_LEN = mwcs_pkg::DEF_MAX_SUBSEQ_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [7:0]                      req_char_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mwcs_pkg::BEST_W-1:0]     rsp_best_sum,
   output logic [mwcs_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_wr_en,
   input  logic [mwcs_pkg::LEN_CFG_W-1:0]  csr_wr_data
);
   import mwcs_pkg::*;
   `include "assert_macros.svh"

   localparam int K     = MAX_SUBSEQ_LEN;
   localparam int SUM_W = $clog2(MAX_SUBSEQ_LEN * 255 + 1);
   localparam int CW    = SUM_W + 1;
   localparam int F_AW  = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
   localparam int S_AW  = (MAX_SECOND_LEN > 1) ? $clog2(MAX_SECOND_LEN) : 1;
   localparam int F_LW  = $clog2(MAX_FIRST_LEN + 1);
   localparam int S_LW  = $clog2(MAX_SECOND_LEN + 1);

   // Configuration and string bookkeeping.
   logic [LEN_CFG_W-1:0] len_ff;
   logic [F_LW-1:0]      first_len_ff;
   logic [S_LW-1:0]      second_len_ff;
   logic                 ovf_ff;

   // Sequencer: stage one issues reads, stage two runs the cells.
   state_type   state_ff, state_in;
   logic [F_AW-1:0] i_ff, i_in;
   logic [S_AW-1:0] j_ff, j_in;
   logic        act_ff, act_in;
   logic        stop_ff, stop_in;
   logic        s2_valid_ff;
   logic        s2_first_col_ff;
   logic        s2_first_row_ff;
   logic        s2_last_ff;
   logic [S_AW-1:0] s2_j_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BEST_W-1:0]     best_ff, best_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic        accept;
   action_type  act_code;
   logic        len_zero, len_big, empty;
   logic        last_col, last_row;

   logic [7:0]  first_rd, second_rd;
   logic [K*CW-1:0] row_rd, row_wr;
   logic [CW-1:0]   prev_here [K];
   logic [CW-1:0]   diag_in   [K];
   logic [CW-1:0]   diag_out  [K];
   logic [CW-1:0]   cur_here  [K];
   logic [CW-1:0]   sel;
   cell_ctl_type    ctl;

   assign act_code = action_type'(req_action);
   assign accept   = req_valid && req_ready;
   assign len_zero = (len_ff == '0);
   assign len_big  = (32'(len_ff) > MAX_SUBSEQ_LEN);
   assign empty    = (first_len_ff == '0) || (second_len_ff == '0);
   assign last_col = (S_LW'(j_ff) + S_LW'(1) == second_len_ff);
   assign last_row = (F_LW'(i_ff) + F_LW'(1) == first_len_ff);

   // A compute needs the response slot free; loads do not.
   assign req_ready = (state_ff == ST_IDLE) && !(act_code == ACT_COMPUTE && rsp_valid_ff);

   // String stores and the rolling row of scores.
   mwcs_ram #(.WIDTH(8), .DEPTH(MAX_FIRST_LEN)) u_first (
      .clock  (clock),
      .wr_en  (accept && act_code == ACT_FIRST && first_len_ff != F_LW'(MAX_FIRST_LEN)),
      .wr_addr(F_AW'(first_len_ff)),
      .wr_data(req_char_value),
      .rd_addr(i_ff),
      .rd_data(first_rd)
   );

   mwcs_ram #(.WIDTH(8), .DEPTH(MAX_SECOND_LEN)) u_second (
      .clock  (clock),
      .wr_en  (accept && act_code == ACT_SECOND && second_len_ff != S_LW'(MAX_SECOND_LEN)),
      .wr_addr(S_AW'(second_len_ff)),
      .wr_data(req_char_value),
      .rd_addr(j_ff),
      .rd_data(second_rd)
   );

   mwcs_ram #(.WIDTH(K * CW), .DEPTH(MAX_SECOND_LEN)) u_row (
      .clock  (clock),
      .wr_en  (s2_valid_ff),
      .wr_addr(s2_j_ff),
      .wr_data(row_wr),
      .rd_addr(j_ff),
      .rd_data(row_rd)
   );

   // Control shared by every cell of the chain.
   always_comb begin
      ctl.en        = s2_valid_ff;
      ctl.first_col = s2_first_col_ff;
      ctl.match     = (first_rd == second_rd);
      ctl.ch        = first_rd;
   end

   // Cell k handles length k + 1. The diagonal input is the neighbor's
   // previous-row score one column back; the length-zero column is always 0.
   for (genvar k = 0; k < K; k++) begin : g_cell
      always_comb begin
         prev_here[k] = row_rd[k*CW +: CW];
         if (s2_first_row_ff) begin
            prev_here[k][SUM_W] = 1'b0;
         end
         if (k == 0) begin
            diag_in[k] = {1'b1, {SUM_W{1'b0}}};
         end else begin
            diag_in[k] = diag_out[(k > 0) ? k - 1 : 0];
            if (s2_first_col_ff) begin
               diag_in[k][SUM_W] = 1'b0;
            end
         end
      end

      mwcs_cell #(.SUM_W(SUM_W)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .prev_here(prev_here[k]),
         .diag_in  (diag_in[k]),
         .diag_out (diag_out[k]),
         .cur_here (cur_here[k])
      );

      assign row_wr[k*CW +: CW] = cur_here[k];
   end

   // Pick the cell whose length matches the configured one.
   always_comb begin
      sel = '0;
      for (int k = 0; k < K; k++) begin
         if (32'(len_ff) == k + 1) begin
            sel = cur_here[k];
         end
      end
   end

   // Sequencer and response word.
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      act_in       = act_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff;
      best_in      = best_ff;
      status_in    = status_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && act_code == ACT_COMPUTE) begin
               if (len_zero || len_big || empty) begin
                  rsp_valid_in = 1'b1;
                  best_in      = '0;
                  status_in    = (ovf_ff) ? STAT_OVERFLOW :
                                 (len_zero) ? STAT_FOUND : STAT_NONE;
               end else begin
                  state_in = ST_RUN;
                  i_in     = '0;
                  j_in     = '0;
                  act_in   = 1'b1;
                  stop_in  = 1'b0;
               end
            end
         end
         ST_RUN: begin
            if (act_ff) begin
               if (last_col) begin
                  act_in  = 1'b0;
                  j_in    = '0;
                  i_in    = i_ff + F_AW'(1);
                  stop_in = last_row;
               end else begin
                  j_in = j_ff + S_AW'(1);
               end
            end else begin
               act_in = !stop_ff;
            end
            if (s2_valid_ff && s2_last_ff) begin
               state_in     = ST_IDLE;
               act_in       = 1'b0;
               rsp_valid_in = 1'b1;
               if (!sel[SUM_W]) begin
                  best_in   = '0;
                  status_in = STAT_NONE;
               end else begin
                  best_in   = (32'(sel[SUM_W-1:0]) > 32'd4095) ? '1 : BEST_W'(sel[SUM_W-1:0]);
                  status_in = STAT_FOUND;
               end
               if (ovf_ff) begin
                  status_in = STAT_OVERFLOW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         act_ff        <= 1'b0;
         stop_ff       <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         len_ff        <= LEN_RESET;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         stop_ff      <= stop_in;
         s2_valid_ff  <= (state_ff == ST_RUN) && act_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (accept) begin
            case (act_code)
               ACT_CLEAR: begin
                  first_len_ff  <= '0;
                  second_len_ff <= '0;
                  ovf_ff        <= 1'b0;
               end
               ACT_FIRST: begin
                  if (first_len_ff != F_LW'(MAX_FIRST_LEN)) begin
                     first_len_ff <= first_len_ff + F_LW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               ACT_SECOND: begin
                  if (second_len_ff != S_LW'(MAX_SECOND_LEN)) begin
                     second_len_ff <= second_len_ff + S_LW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      j_ff            <= j_in;
      best_ff         <= best_in;
      status_ff       <= status_in;
      s2_j_ff         <= j_ff;
      s2_first_col_ff <= (j_ff == '0);
      s2_first_row_ff <= (i_ff == '0);
      s2_last_ff      <= last_col && last_row;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = best_ff;
   assign rsp_status   = status_ff;

   // The cell pipeline only runs while a compute is in progress.
   `ASSERT_IMPL(a_s2_in_run, clock, reset, s2_valid_ff, state_ff == ST_RUN)
   // A compute finishing never overwrites a word still waiting.
   `ASSERT_IMPL(a_no_clobber, clock, reset, s2_valid_ff && s2_last_ff, !rsp_valid_ff)
   // An accepted compute either answers next cycle or starts the walk.
   `ASSERT_NEXT(a_compute_starts, clock, reset, accept && act_code == ACT_COMPUTE,
      rsp_valid_ff || state_ff == ST_RUN)
endmodule

FILE: tb/sv/max_weight_common_subsequence_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_weight_common_subsequence_tb
// Self-checking bench for the max-weight common subsequence engine.
// ----------------------------------------------------------------------------
// Load and compute words are queued by the stimulus process and driven by a
// clocked driver with random idle bursts. A software scorer predicts the
// best sum and status of every compute as it is accepted. A monitor checks
// every response word against the oldest prediction.
// ----------------------------------------------------------------------------
module max_weight_common_subsequence_tb;
   import mwcs_pkg::*;

   localparam int FIRST_CAP  = DEF_MAX_FIRST_LEN;
   localparam int SECOND_CAP = DEF_MAX_SECOND_LEN;
   localparam int LEN_CAP    = DEF_MAX_SUBSEQ_LEN;
   localparam int STALL_LIMIT = 40000;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      action_type action;
      logic [7:0] ch;
   } req_word_type;

   typedef struct packed {
      logic [BEST_W-1:0]   best_sum;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = ACT_CLEAR;
   logic [7:0] req_char_value = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BEST_W-1:0] rsp_best_sum;
   logic [STATUS_W-1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [LEN_CFG_W-1:0] csr_wr_data = '0;

   max_weight_common_subsequence u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_char_value(req_char_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_best_sum(rsp_best_sum), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus words waiting for the driver, and predictions waiting for the
   // monitor.
   req_word_type pending_words[$];
   rsp_word_type expected_sums[$];

   // Scorer's copy of the block state.
   logic [7:0] first_bytes[FIRST_CAP];
   logic [7:0] second_bytes[SECOND_CAP];
   int first_count = 0;
   int second_count = 0;
   bit overflow_flag = 1'b0;
   logic [LEN_CFG_W-1:0] target_len = LEN_RESET;

   int errors = 0;
   bit quiet_tail = 1'b0;
   bit long_hold_go = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_count = 0;
   int idle_cycles = 0;
   int sent_words = 0;

   // Two-row dynamic program; -1 marks a cell with no subsequence.
   function automatic int best_common_sum(int len);
      int prev_row[SECOND_CAP+1][LEN_CAP+1];
      int cur_row[SECOND_CAP+1][LEN_CAP+1];
      int v;
      int take;
      for (int j = 0; j <= second_count; j++)
         for (int k = 0; k <= len; k++)
            prev_row[j][k] = (k == 0) ? 0 : -1;
      for (int i = 1; i <= first_count; i++) begin
         for (int k = 0; k <= len; k++)
            cur_row[0][k] = (k == 0) ? 0 : -1;
         for (int j = 1; j <= second_count; j++) begin
            cur_row[j][0] = 0;
            for (int k = 1; k <= len; k++) begin
               v = (prev_row[j][k] > cur_row[j-1][k]) ? prev_row[j][k] : cur_row[j-1][k];
               if (first_bytes[i-1] == second_bytes[j-1] && prev_row[j-1][k-1] != -1) begin
                  take = prev_row[j-1][k-1] + int'(first_bytes[i-1]);
                  if (take > v)
                     v = take;
               end
               cur_row[j][k] = v;
            end
         end
         prev_row = cur_row;
      end
      return prev_row[second_count][len];
   endfunction

   // Applies one accepted word to the scorer and queues any prediction.
   task automatic score_word(req_word_type w);
      rsp_word_type r;
      int best;
      case (w.action)
         ACT_CLEAR: begin
            first_count = 0;
            second_count = 0;
            overflow_flag = 1'b0;
         end
         ACT_FIRST: begin
            if (first_count < FIRST_CAP) begin
               first_bytes[first_count] = w.ch;
               first_count++;
            end else overflow_flag = 1'b1;
         end
         ACT_SECOND: begin
            if (second_count < SECOND_CAP) begin
               second_bytes[second_count] = w.ch;
               second_count++;
            end else overflow_flag = 1'b1;
         end
         default: begin
            r.best_sum = '0;
            r.status = STAT_FOUND;
            if (target_len == 0) r.status = STAT_FOUND;
            else if (target_len > LEN_CAP) r.status = STAT_NONE;
            else begin
               best = best_common_sum(target_len);
               if (best < 0) r.status = STAT_NONE;
               else r.best_sum = (best > 4095) ? 12'hFFF : best[BEST_W-1:0];
            end
            if (overflow_flag) r.status = STAT_OVERFLOW;
            expected_sums = {expected_sums, r};
         end
      endcase
   endtask

   // Handshake is sampled on the rising edge for acceptance bookkeeping.
   bit req_fire;
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   // Driver: inputs change on the falling edge. Valid holds until accepted.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            score_word(pending_words.pop_front());
            if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
         end
         if (!(req_valid && !req_fire)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= pending_words[0].action;
               req_char_value <= pending_words[0].ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness with random stall bursts and one long hold, which
   // this process counts out itself once the stimulus asks for it.
   int recv_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold_go && !long_hold_done) begin
            rsp_ready <= 1'b0;
            hold_count++;
            if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 4);
         end
      end
   end

   // Monitor: checks each accepted response word against the oldest prediction.
   rsp_word_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sums.size() == 0) begin
            $error("unexpected response word best_sum=%0d status=%0d", rsp_best_sum, rsp_status);
            errors++;
         end else begin
            want = expected_sums.pop_front();
            if (rsp_best_sum !== want.best_sum) begin
               $error("best_sum expected %0d actual %0d", want.best_sum, rsp_best_sum);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (req_valid || expected_sums.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL max_weight_common_subsequence");
            $finish;
         end
      end
   end

   task automatic push_word(action_type a, logic [7:0] c);
      req_word_type w;
      w.action = a;
      w.ch = c;
      pending_words = {pending_words, w};
      sent_words++;
   endtask

   // Waits until every queued word is taken and every response has arrived,
   // plus a drain for a compute that might still be running.
   task automatic drain_all();
      while (pending_words.size() > 0 || req_valid || expected_sums.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_CFG_W-1:0] len);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      target_len = len;
   endtask

   // A clear, a pair of random strings over a chosen alphabet, then a compute.
   task automatic push_pair(int n, int m, int alpha);
      push_word(ACT_CLEAR, 8'($urandom));
      for (int i = 0; i < n; i++)
         push_word(ACT_FIRST, 8'($urandom_range(0, alpha)) ^ 8'(alpha == 255 ? 0 : 8'hF0));
      for (int j = 0; j < m; j++)
         push_word(ACT_SECOND, 8'($urandom_range(0, alpha)) ^ 8'(alpha == 255 ? 0 : 8'hF0));
      push_word(ACT_COMPUTE, 8'($urandom));
   endtask

   int len_choice;

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes, length 1 match, no match, empty strings.
      push_word(ACT_COMPUTE, 8'h00);
      push_word(ACT_FIRST, 8'hFF);
      push_word(ACT_SECOND, 8'hFF);
      push_word(ACT_COMPUTE, 8'hFF);
      push_word(ACT_FIRST, 8'h00);
      push_word(ACT_SECOND, 8'h00);
      push_word(ACT_COMPUTE, 8'h55);
      push_word(ACT_CLEAR, 8'hAA);
      push_word(ACT_FIRST, 8'h01);
      push_word(ACT_SECOND, 8'h02);
      push_word(ACT_COMPUTE, 8'h00);
      drain_all();

      // Length zero and length above the table size.
      write_length(5'd0);
      push_word(ACT_COMPUTE, 8'h00);
      drain_all();
      write_length(5'd31);
      push_word(ACT_COMPUTE, 8'h00);
      drain_all();
      write_length(5'd17);
      push_word(ACT_COMPUTE, 8'h00);
      drain_all();

      // Full strings of 0xFF at the maximum length, then overflow of both stores.
      write_length(5'd16);
      push_word(ACT_CLEAR, 8'h00);
      for (int i = 0; i < FIRST_CAP; i++) push_word(ACT_FIRST, 8'hFF);
      for (int j = 0; j < SECOND_CAP; j++) push_word(ACT_SECOND, 8'hFF);
      push_word(ACT_COMPUTE, 8'h00);
      push_word(ACT_FIRST, 8'h12);
      push_word(ACT_COMPUTE, 8'h00);
      push_word(ACT_SECOND, 8'h34);
      push_word(ACT_COMPUTE, 8'h00);
      // Overflow with no subsequence still reports the overflow status.
      push_word(ACT_CLEAR, 8'h00);
      for (int i = 0; i <= FIRST_CAP; i++) push_word(ACT_FIRST, 8'h01);
      push_word(ACT_COMPUTE, 8'h00);
      drain_all();

      // Long receiver hold: computes pile up behind the held response word.
      write_length(5'd2);
      long_hold_go = 1'b1;
      for (int r = 0; r < 4; r++) push_pair(6, 6, 3);
      wait (long_hold_done);
      drain_all();

      // Random phases over several lengths; mostly short strings over a
      // small alphabet so that common subsequences exist.
      while (sent_words < 700) begin
         len_choice = $urandom_range(0, 9);
         if (len_choice == 0) write_length(5'($urandom_range(0, 31)));
         else if (len_choice == 1) write_length(5'd16);
         else write_length(5'($urandom_range(1, 5)));
         if (sent_words > 600) quiet_tail = 1'b1;
         for (int p = 0; p < 4; p++) begin
            case ($urandom_range(0, 7))
               0: push_pair($urandom_range(0, 66), $urandom_range(0, 66), 255);
               1: push_word(action_type'($urandom_range(0, 3)), 8'($urandom));
               default: push_pair($urandom_range(1, 12), $urandom_range(1, 12),
                                  $urandom_range(1, 7));
            endcase
         end
         drain_all();
      end

      drain_all();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_sums.size() == 0)
         $display("PASS max_weight_common_subsequence");
      else
         $display("FAIL max_weight_common_subsequence");
      $finish;
   end

endmodule
